>>> rtl/annexb_parameter_set_extractor_assert.svh
// Assertion macros used by the checker module.
`ifndef ANNEXB_PARAMETER_SET_EXTRACTOR_ASSERT_SVH
`define ANNEXB_PARAMETER_SET_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define APSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define APSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/apse_pkg.sv
`timescale 1ns / 1ps
package apse_pkg;

  localparam int BYTE_W      = 8;
  localparam int MAX_RES     = 5;
  localparam int FIFO_DEPTH  = 8;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = PTR_W + 1;
  localparam int RES_CNT_W   = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;

  localparam logic [1:0] KIND_SPS    = 2'd0;
  localparam logic [1:0] KIND_PPS    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS = 5'd8;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_SKIP,
    PH_HEADER,
    PH_UNIT
  } phase_t;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_SPS,
    CAP_PPS
  } cap_t;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] skip;
    cap_t       cap;
    logic       sps;
    logic       pps;
  } pst_t;

  localparam pst_t PST_RESET = '{phase: PH_SEARCH, skip: 2'd0, cap: CAP_NONE,
                                 sps: 1'b0, pps: 1'b0};

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [1:0]        kind;
    logic              unit_last;
    logic              sps_found;
    logic              pps_found;
    logic              run_last;
  } res_t;

  typedef struct packed {
    pst_t st;
    logic emit;
    res_t res;
  } step_t;

  // Look for 00 00 01 or 00 00 00 01 at b0; avail counts bytes after b0.
  function automatic pst_t scan_code(input pst_t st, input logic [7:0] b0,
                                     input logic [7:0] b1, input logic [7:0] b2,
                                     input logic [7:0] b3, input logic [1:0] avail);
    pst_t s;
    s = st;
    if (avail >= 2'd2 && b0 == 8'd0 && b1 == 8'd0) begin
      if (b2 == 8'd1) begin
        s.skip  = 2'd2;
        s.phase = PH_SKIP;
      end else if (avail == 2'd3 && b2 == 8'd0 && b3 == 8'd1) begin
        s.skip  = 2'd3;
        s.phase = PH_SKIP;
      end
    end
    return s;
  endfunction

  // Pass a unit byte through when capturing; close the unit on its last byte.
  function automatic step_t unit_out(input step_t r_in, input logic [7:0] b0,
                                     input logic last);
    step_t r;
    r = r_in;
    if (r.st.cap == CAP_SPS || r.st.cap == CAP_PPS) begin
      r.emit          = 1'b1;
      r.res.data_byte = b0;
      r.res.kind      = (r.st.cap == CAP_SPS) ? KIND_SPS : KIND_PPS;
      r.res.unit_last = last;
      r.res.sps_found = r.st.sps;
      r.res.pps_found = r.st.pps;
      r.res.run_last  = 1'b0;
    end
    if (last) begin
      r.st.phase = PH_SEARCH;
      r.st.cap   = CAP_NONE;
    end
    return r;
  endfunction

  // Decide one buffer position from b0 and up to three bytes after it.
  function automatic step_t proc_at(input pst_t st, input logic [7:0] b0,
                                    input logic [7:0] b1, input logic [7:0] b2,
                                    input logic [7:0] b3, input logic [1:0] avail);
    step_t      r;
    pst_t       tmp;
    logic [4:0] ntype;
    logic       last;
    r.st   = st;
    r.emit = 1'b0;
    r.res  = '0;
    tmp    = st;
    ntype  = b0[4:0];
    last   = (avail == 2'd0) ||
             (avail == 2'd3 && b1 == 8'd0 && b2 == 8'd0 && b3 <= 8'd1);
    case (st.phase)
      PH_SEARCH: begin
        r.st = scan_code(st, b0, b1, b2, b3, avail);
      end
      PH_SKIP: begin
        if (st.skip != 2'd0) r.st.skip = st.skip - 2'd1;
        if (st.skip <= 2'd1) r.st.phase = PH_HEADER;
      end
      PH_HEADER: begin
        if (avail >= 2'd2 && b0 == 8'd0 && b1 == 8'd0 && b2 <= 8'd1) begin
          // empty unit: resume the search right here
          tmp.phase = PH_SEARCH;
          r.st = scan_code(tmp, b0, b1, b2, b3, avail);
        end else begin
          r.st.cap = CAP_NONE;
          if (ntype == NAL_TYPE_SPS && !st.sps) begin
            r.st.cap = CAP_SPS;
            r.st.sps = 1'b1;
          end else if (ntype == NAL_TYPE_PPS && !st.pps) begin
            r.st.cap = CAP_PPS;
            r.st.pps = 1'b1;
          end
          r.st.phase = PH_UNIT;
          r = unit_out(r, b0, last);
        end
      end
      default: begin
        r = unit_out(r, b0, last);
      end
    endcase
    return r;
  endfunction

endpackage

>>> rtl/apse_parser.sv
`timescale 1ns / 1ps
module apse_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_fire,
  input  logic [apse_pkg::BYTE_W-1:0]       in_byte,
  input  logic                              in_end,
  output logic [apse_pkg::RES_CNT_W-1:0]    res_cnt,
  output apse_pkg::res_t [apse_pkg::MAX_RES-1:0] res_vec
);
  import apse_pkg::*;

  logic [BYTE_W-1:0] win_r [3];
  logic [BYTE_W-1:0] win_nxt [3];
  logic [1:0]        fill_r;
  logic [1:0]        fill_nxt;
  pst_t              st_r;
  pst_t              st_nxt;

  logic [BYTE_W-1:0] buf_b [7];
  logic [2:0]        k;
  logic [2:0]        av;
  logic [1:0]        step_av;
  logic              step_en;
  pst_t              chain [5];
  step_t             step;
  logic [3:0]        emit;
  res_t              res_t_v [4];
  res_t              status;
  logic [RES_CNT_W-1:0] cnt;
  res_t [MAX_RES-1:0]   vec;

  // Assemble window plus the new byte, zeros past the end.
  always_comb begin
    for (int i = 0; i < 7; i++) buf_b[i] = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < fill_r) buf_b[i] = win_r[i];
    end
    buf_b[{1'b0, fill_r}] = in_byte;
    k = {1'b0, fill_r} + 3'd1;
  end

  // Up to four positions decided in a row on the flagged byte.
  always_comb begin
    chain[0] = st_r;
    emit     = '0;
    for (int t = 0; t < 4; t++) begin
      res_t_v[t] = '0;
      av         = k - 3'd1 - 3'(t);
      step_en    = in_end ? (3'(t) < k) : (t == 0 && fill_r == 2'd3);
      step_av    = in_end ? av[1:0] : 2'd3;
      step       = proc_at(chain[t], buf_b[t], buf_b[t+1], buf_b[t+2], buf_b[t+3],
                           step_av);
      if (step_en) begin
        chain[t+1] = step.st;
        emit[t]    = step.emit;
        res_t_v[t] = step.res;
      end else begin
        chain[t+1] = chain[t];
      end
    end
  end

  // Pack emitted words; append the status word on the flagged byte, else set run_last on word 0.
  always_comb begin
    status           = '0;
    status.kind      = KIND_STATUS;
    status.sps_found = chain[4].sps;
    status.pps_found = chain[4].pps;
    status.run_last  = 1'b1;
    cnt = '0;
    vec = '0;
    for (int t = 0; t < 4; t++) begin
      if (emit[t]) begin
        vec[cnt] = res_t_v[t];
        cnt      = cnt + 3'd1;
      end
    end
    if (in_end) begin
      vec[cnt] = status;
      cnt      = cnt + 3'd1;
    end else if (cnt != '0) begin
      vec[0].run_last = 1'b1;
    end
    res_cnt = in_fire ? cnt : '0;
    res_vec = vec;
  end

  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    st_nxt   = st_r;
    if (in_fire) begin
      if (in_end) begin
        fill_nxt = 2'd0;
        st_nxt   = PST_RESET;
      end else if (fill_r == 2'd3) begin
        win_nxt[0] = buf_b[1];
        win_nxt[1] = buf_b[2];
        win_nxt[2] = buf_b[3];
        st_nxt     = chain[1];
      end else begin
        win_nxt[fill_r] = in_byte;
        fill_nxt        = fill_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
      st_r   <= PST_RESET;
    end else begin
      fill_r <= fill_nxt;
      st_r   <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

>>> rtl/apse_fifo.sv
`timescale 1ns / 1ps
module apse_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [apse_pkg::RES_CNT_W-1:0] wr_cnt,
  input  apse_pkg::res_t [apse_pkg::MAX_RES-1:0] wr_data,
  output logic                           space_ok,
  output logic                           rd_valid,
  input  logic                           rd_ready,
  output apse_pkg::res_t                 rd_data
);
  import apse_pkg::*;

  res_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  // leave room for a full burst of one input
  assign space_ok = (cnt_r <= CNT_W'(FIFO_DEPTH - MAX_RES));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(wr_cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    cnt_nxt    = cnt_r + CNT_W'(wr_cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_RES; j++) begin
      if (RES_CNT_W'(j) < wr_cnt) mem_r[wr_ptr_r + PTR_W'(j)] <= wr_data[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/annexb_parameter_set_extractor.sv
`timescale 1ns / 1ps
// Channel  | Ports                  | Word layout (low bit first)
// ---------+------------------------+------------------------------------------
// in       | in_tvalid/tready/...   | tdata: in_byte[7:0]; tlast: end_of_buffer
// out      | out_tvalid/tready/...  | tdata: out_byte[7:0], sps_found, pps_found,
//          |                        |        run_last, zeros; tuser: kind;
//          |                        |        tlast: unit_last
//
// One input word per clock while in_tready is high; its results are written
// into the result queue on the accepting edge and leave one per clock, while
// out_tready is high, from the next cycle on, so a flagged last byte yields up
// to five results at the output. Input stalls only while the eight-entry result
// queue has fewer than five free slots. Reset (synchronous, rst_n low) empties
// the queue and the parser state; the three-byte window needs no reset.
module annexb_parameter_set_extractor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [apse_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] in_byte
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [apse_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [7:0] out_byte, [8] sps_found,
                                                          // [9] pps_found, [10] run_last
  output logic [apse_pkg::OUT_TUSER_W-1:0]    out_tuser,  // [1:0] kind
  output logic                                out_tlast
);
  import apse_pkg::*;

  logic                    in_fire;
  logic                    space_ok;
  logic [RES_CNT_W-1:0]    res_cnt;
  res_t [MAX_RES-1:0]      res_vec;
  res_t                    head;

  assign in_tready = space_ok;
  assign in_fire   = in_tvalid && in_tready;

  apse_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata[BYTE_W-1:0]),
    .in_end  (in_tlast),
    .res_cnt (res_cnt),
    .res_vec (res_vec)
  );

  apse_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cnt   (res_cnt),
    .wr_data  (res_vec),
    .space_ok (space_ok),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (head)
  );

  assign out_tdata = {(OUT_TDATA_W - BYTE_W - 3)'(0), head.run_last, head.pps_found,
                      head.sps_found, head.data_byte};
  assign out_tuser = head.kind;
  assign out_tlast = head.unit_last;

endmodule

>>> rtl/apse_checker.sv
`timescale 1ns / 1ps
`include "annexb_parameter_set_extractor_assert.svh"
module apse_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [apse_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [apse_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                             out_tlast
);
  import apse_pkg::*;

  `APSE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled output word changed")

  `APSE_ASSERT_NOW(a_status_shape, out_tvalid && out_tuser == KIND_STATUS, out_tdata[10] && out_tdata[7:0] == 8'd0 && !out_tlast, "malformed status word")

  `APSE_ASSERT_NOW(a_found_flags, out_tvalid, (out_tuser != KIND_SPS || out_tdata[8]) && (out_tuser != KIND_PPS || out_tdata[9]), "unit byte without found flag")

  `APSE_ASSERT_NOW(a_stall_has_data, !in_tready, out_tvalid, "input stalled with empty queue")

endmodule

bind annexb_parameter_set_extractor apse_checker u_apse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> bench/annexb_parameter_set_extractor_tb.sv
`timescale 1ns / 1ps
module annexb_parameter_set_extractor_tb;
  import apse_pkg::*;

  localparam int RANDOM_WORDS   = 250;
  localparam int STALL_LIMIT    = 1000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_AFTER     = 150;
  localparam int HOLD_CYCLES    = 120;
  localparam int DIRECTED_COUNT = 23;

  // {end_of_buffer, byte}
  localparam logic [8:0] DIRECTED_WORDS [DIRECTED_COUNT] = '{
    // 4-byte code + SPS, 3-byte code into an empty unit, PPS, repeated SPS
    9'h000, 9'h000, 9'h000, 9'h001, 9'h067, 9'h0AA,
    9'h000, 9'h000, 9'h001, 9'h000, 9'h000, 9'h001, 9'h068, 9'h0BB,
    9'h000, 9'h000, 9'h001, 9'h0E7, 9'h1FF,
    // start code cut off by the buffer end
    9'h000, 9'h000, 9'h101,
    // one-byte buffer
    9'h1FF
  };

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } in_word_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  in_word_t    pending_words[$];
  logic [7:0]  stream_bytes[$];
  res_t        expected_results[$];
  res_t        word_results[$];
  int unsigned total_words     = 0;
  int unsigned accepted_words  = 0;
  int unsigned awaited_results = 0;
  int unsigned error_count     = 0;
  int unsigned idle_cycles     = 0;
  int unsigned burst_left      = 0;
  int unsigned gap_left        = 0;
  int unsigned hold_left       = 0;
  int unsigned ready_mode      = 0;
  int unsigned mode_left       = 0;
  bit          timed_out       = 1'b0;
  bit          holding_off     = 1'b0;
  bit          hold_done       = 1'b0;

  // Shadow parser state
  logic [7:0]  win_bytes[0:2];
  logic [7:0]  lane[0:7];
  int unsigned win_count;
  phase_t      prs_phase;
  int unsigned code_bytes_left;
  cap_t        grab;
  logic        sps_seen;
  logic        pps_seen;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  annexb_parameter_set_extractor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  task automatic clear_parser();
    win_count       = 0;
    prs_phase       = PH_SEARCH;
    code_bytes_left = 0;
    grab            = CAP_NONE;
    sps_seen        = 1'b0;
    pps_seen        = 1'b0;
  endtask

  task automatic add_result(logic [7:0] b, logic [1:0] k, logic last);
    res_t r;
    r.data_byte = b;
    r.kind      = k;
    r.unit_last = last;
    r.sps_found = sps_seen;
    r.pps_found = pps_seen;
    r.run_last  = 1'b0;
    word_results = {word_results, r};
  endtask

  // Arm the code skip if 00 00 01 or 00 00 00 01 begins at pos.
  task automatic look_for_start_code(int unsigned pos, int unsigned avail);
    int unsigned len;
    len = 0;
    if (avail >= 2 && lane[pos] == 8'h00 && lane[pos+1] == 8'h00) begin
      if (lane[pos+2] == 8'h01)
        len = 3;
      else if (avail >= 3 && lane[pos+2] == 8'h00 && lane[pos+3] == 8'h01)
        len = 4;
    end
    if (len != 0) begin
      code_bytes_left = len - 1;
      prs_phase       = PH_SKIP;
    end
  endtask

  task automatic emit_unit_byte(int unsigned pos, int unsigned avail);
    logic last;
    last = (avail == 0) || (avail >= 3 && lane[pos+1] == 8'h00 &&
                            lane[pos+2] == 8'h00 && lane[pos+3] <= 8'h01);
    if (grab == CAP_SPS)
      add_result(lane[pos], KIND_SPS, last);
    else if (grab == CAP_PPS)
      add_result(lane[pos], KIND_PPS, last);
    if (last) begin
      prs_phase = PH_SEARCH;
      grab      = CAP_NONE;
    end
  endtask

  task automatic decide_position(int unsigned pos, int unsigned avail);
    case (prs_phase)
      PH_SEARCH: look_for_start_code(pos, avail);
      PH_SKIP: begin
        if (code_bytes_left > 0) code_bytes_left--;
        if (code_bytes_left == 0) prs_phase = PH_HEADER;
      end
      PH_HEADER: begin
        if (avail >= 2 && lane[pos] == 8'h00 && lane[pos+1] == 8'h00 &&
            lane[pos+2] <= 8'h01) begin
          // empty unit: the header slot already opens the next code
          prs_phase = PH_SEARCH;
          look_for_start_code(pos, avail);
        end else begin
          grab = CAP_NONE;
          if (lane[pos][4:0] == NAL_TYPE_SPS && !sps_seen) begin
            grab     = CAP_SPS;
            sps_seen = 1'b1;
          end else if (lane[pos][4:0] == NAL_TYPE_PPS && !pps_seen) begin
            grab     = CAP_PPS;
            pps_seen = 1'b1;
          end
          prs_phase = PH_UNIT;
          emit_unit_byte(pos, avail);
        end
      end
      default: emit_unit_byte(pos, avail);
    endcase
  endtask

  task automatic predict_word(logic [7:0] data, logic eob);
    int unsigned n;
    int unsigned t;
    res_t        r;
    word_results.delete();
    for (t = 0; t < 8; t++) lane[t] = 8'h00;
    for (t = 0; t < win_count; t++) lane[t] = win_bytes[t];
    lane[win_count] = data;
    n = win_count + 1;
    if (!eob) begin
      if (n == 4) begin
        decide_position(0, 3);
        for (t = 0; t < 3; t++) win_bytes[t] = lane[t+1];
        win_count = 3;
      end else begin
        for (t = 0; t < 3; t++) win_bytes[t] = lane[t];
        win_count = n;
      end
    end else begin
      // drain the window, then report and start over
      for (t = 0; t < n; t++) decide_position(t, n - 1 - t);
      add_result(8'h00, KIND_STATUS, 1'b0);
      clear_parser();
    end
    if (word_results.size() != 0) begin
      r = word_results.pop_back();
      r.run_last = 1'b1;
      word_results = {word_results, r};
    end
    foreach (word_results[i]) expected_results = {expected_results, word_results[i]};
    awaited_results += word_results.size();
  endtask

  function automatic logic [7:0] mixed_byte();
    case ($urandom_range(0, 7))
      0, 1:    return 8'h00;
      2:       return 8'h01;
      3:       return 8'h03;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic flush_buffer();
    in_word_t w;
    foreach (stream_bytes[i]) begin
      w.data = stream_bytes[i];
      w.eob  = (i == stream_bytes.size() - 1);
      pending_words = {pending_words, w};
    end
  endtask

  // Mostly well-formed unit sequences; some noise and cut-off tails.
  task automatic build_random_buffer();
    int unsigned units;
    int unsigned plen;
    int unsigned u;
    int unsigned i;
    logic [4:0]  nal;
    stream_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      plen = $urandom_range(1, 12);
      for (i = 0; i < plen; i++) stream_bytes = {stream_bytes, mixed_byte()};
    end else begin
      for (i = $urandom_range(0, 2); i > 0; i--) stream_bytes = {stream_bytes, mixed_byte()};
      units = $urandom_range(1, 3);
      for (u = 0; u < units; u++) begin
        if ($urandom_range(0, 1) == 1) stream_bytes = {stream_bytes, 8'h00};
        stream_bytes = {stream_bytes, 8'h00};
        stream_bytes = {stream_bytes, 8'h00};
        stream_bytes = {stream_bytes, 8'h01};
        case ($urandom_range(0, 5))
          0, 1:    nal = NAL_TYPE_SPS;
          2, 3:    nal = NAL_TYPE_PPS;
          4:       nal = 5'd5;
          default: nal = 5'($urandom_range(0, 31));
        endcase
        stream_bytes = {stream_bytes, {3'($urandom_range(0, 7)), nal}};
        plen = $urandom_range(0, 6);
        for (i = 0; i < plen; i++) stream_bytes = {stream_bytes, mixed_byte()};
      end
      if ($urandom_range(0, 7) == 0)
        for (i = $urandom_range(1, 3); i > 0 && stream_bytes.size() > 1; i--)
          void'(stream_bytes.pop_back());
    end
    flush_buffer();
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // Sender: bursts of words with random gaps; hold a word until taken.
  always @(posedge clk) begin
    logic show;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_word(in_tdata[7:0], in_tlast);
        pending_words.delete(0);
        accepted_words++;
      end
      show = 1'b0;
      if (pending_words.size() != 0) begin
        if ((in_tvalid && !in_tready) || holding_off) begin
          show = 1'b1;
        end else if (gap_left != 0) begin
          gap_left--;
        end else begin
          show = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_tvalid <= show;
      if (show) begin
        in_tdata <= pending_words[0].data;
        in_tlast <= pending_words[0].eob;
      end
    end
  end

  // Receiver: check each word, then pick the next ready level.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    logic ready;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.data_byte = out_tdata[7:0];
        got.sps_found = out_tdata[8];
        got.pps_found = out_tdata[9];
        got.run_last  = out_tdata[10];
        got.kind      = out_tuser;
        got.unit_last = out_tlast;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: out_byte %02h kind %0d",
                 got.data_byte, got.kind);
          error_count++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          awaited_results--;
          check_field("out_byte", want.data_byte, got.data_byte);
          check_field("kind", want.kind, got.kind);
          check_field("unit_last", want.unit_last, got.unit_last);
          check_field("sps_found", want.sps_found, got.sps_found);
          check_field("pps_found", want.pps_found, got.pps_found);
          check_field("run_last", want.run_last, got.run_last);
        end
      end
      // one long hold-off so the result queue fills and backs up the input
      if (!hold_done && accepted_words >= HOLD_AFTER) begin
        hold_done   = 1'b1;
        hold_left   = HOLD_CYCLES;
        holding_off = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        holding_off = (hold_left != 0);
        ready       = 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(20, 80);
        end else begin
          mode_left--;
        end
        case (ready_mode)
          0:       ready = 1'b1;
          1:       ready = ($urandom_range(0, 1) == 1);
          default: ready = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_tready <= ready;
    end
  end

  always @(posedge clk) begin
    if (rst_n && !timed_out) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) timed_out = 1'b1;
      end
    end
  end

  initial begin
    in_word_t    w;
    int unsigned i;
    clear_parser();
    for (i = 0; i < DIRECTED_COUNT; i++) begin
      w.data = DIRECTED_WORDS[i][7:0];
      w.eob  = DIRECTED_WORDS[i][8];
      pending_words = {pending_words, w};
    end
    while (pending_words.size() < DIRECTED_COUNT + RANDOM_WORDS) build_random_buffer();
    total_words = pending_words.size();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    fork
      begin
        wait (accepted_words == total_words && awaited_results == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      wait (timed_out);
    join_any
    if (awaited_results != 0) begin
      $error("%0d expected results never arrived", awaited_results);
      error_count++;
    end
    if (!timed_out && error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/apse_pkg.sv
rtl/apse_parser.sv
rtl/apse_fifo.sv
rtl/annexb_parameter_set_extractor.sv
rtl/apse_checker.sv
bench/annexb_parameter_set_extractor_tb.sv
